// File: rtl/bmxe_pkg.sv
// ----------------------------------------------------------------------------
// bmxe_pkg
// Shared types, constants and helpers for the bit-matrix XOR erasure encoder.
// ----------------------------------------------------------------------------
package bmxe_pkg;

  // Field widths fixed by the interface
  localparam int DATA_W  = 64;
  localparam int COL_W   = 6;
  localparam int ROW_W   = 6;
  localparam int WIDX_W  = 4;
  localparam int PART_W  = 4;
  localparam int CNT_W   = 7;   // holds row / column counts up to 64
  localparam int ADDR_W  = 3;
  localparam int PDATA_W = 32;

  // Defaults for the top-level parameters
  localparam int WORD_BITS_DEF    = 8;
  localparam int PACKET_WORDS_DEF = 16;
  localparam int MAX_ROWS_DEF     = 64;

  // Part counts
  localparam logic [PART_W-1:0] MIN_PARTS = 4'd1;
  localparam logic [PART_W-1:0] MAX_PARTS = 4'd8;
  localparam logic [PART_W-1:0] DATA_PARTS_RST = 4'd4;
  localparam logic [PART_W-1:0] CODE_PARTS_RST = 4'd2;

  // Register index, taken from paddr[2]
  localparam int REG_IDX_BIT = 2;
  localparam logic REG_DATA_PARTS = 1'b0;
  localparam logic REG_CODE_PARTS = 1'b1;

  // Request commands
  localparam logic CMD_ROW_LOAD = 1'b0;
  localparam logic CMD_DATA     = 1'b1;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [PART_W-1:0] data_parts;
    logic [PART_W-1:0] code_parts;
  } cfg_t;

  // Token that walks the cell chain
  typedef struct packed {
    logic              vld;
    logic              col0;   // first column: overwrite accumulator
    logic              emit;   // last column: every row reports
    logic [COL_W-1:0]  column;
    logic [WIDX_W-1:0] word_index;
    logic [DATA_W-1:0] data;
  } tok_t;

  // Matrix row load, broadcast to all cells
  typedef struct packed {
    logic              we;
    logic [ROW_W-1:0]  row_sel;
    logic [DATA_W-1:0] bits;
  } load_t;

  // Per-cell status back to the top level
  typedef struct packed {
    logic              tok_vld;
    logic              res_vld;
    logic              fin;      // token sits on the final active row
    logic [DATA_W-1:0] word;
  } cell_stat_t;

  // Zero acts as one, above eight acts as eight
  function automatic logic [PART_W-1:0] clamp_parts(input logic [PART_W-1:0] v);
    logic [PART_W-1:0] r;
    if (v < MIN_PARTS) r = MIN_PARTS;
    else if (v > MAX_PARTS) r = MAX_PARTS;
    else r = v;
    return r;
  endfunction

endpackage

// File: rtl/bmxe_cfg_regs.sv
// ----------------------------------------------------------------------------
// bmxe_cfg_regs
// APB register file holding the data and code part counts.
// ----------------------------------------------------------------------------
module bmxe_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bmxe_pkg::ADDR_W-1:0]   paddr,
  input  logic [bmxe_pkg::PDATA_W-1:0]  pwdata,
  output logic [bmxe_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output bmxe_pkg::cfg_t                cfg
);

  logic [bmxe_pkg::PART_W-1:0] data_parts_r;
  logic [bmxe_pkg::PART_W-1:0] code_parts_r;
  logic                        wr_en;
  logic                        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[bmxe_pkg::REG_IDX_BIT];

  // Register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_parts_r <= bmxe_pkg::DATA_PARTS_RST;
      code_parts_r <= bmxe_pkg::CODE_PARTS_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        bmxe_pkg::REG_DATA_PARTS: data_parts_r <= pwdata[bmxe_pkg::PART_W-1:0];
        bmxe_pkg::REG_CODE_PARTS: code_parts_r <= pwdata[bmxe_pkg::PART_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    unique case (reg_sel)
      bmxe_pkg::REG_DATA_PARTS: prdata = bmxe_pkg::PDATA_W'(data_parts_r);
      bmxe_pkg::REG_CODE_PARTS: prdata = bmxe_pkg::PDATA_W'(code_parts_r);
      default:                  prdata = '0;
    endcase
  end

  assign cfg.data_parts = data_parts_r;
  assign cfg.code_parts = code_parts_r;

endmodule

// File: rtl/bmxe_cell.sv
// ----------------------------------------------------------------------------
// bmxe_cell
// One code row: its matrix row, its accumulator memory and one token stage.
// ----------------------------------------------------------------------------
module bmxe_cell #(
  parameter int                           PACKET_WORDS = bmxe_pkg::PACKET_WORDS_DEF,
  parameter logic [bmxe_pkg::ROW_W-1:0]   ROW_ID       = '0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,      // chain may move this cycle
  input  logic [bmxe_pkg::ROW_W-1:0]   last_row,  // final active row
  input  bmxe_pkg::load_t              load,
  input  bmxe_pkg::tok_t               tok_in,
  output bmxe_pkg::tok_t               tok_out,
  output bmxe_pkg::cell_stat_t         stat
);

  localparam int AW = (PACKET_WORDS > 1) ? $clog2(PACKET_WORDS) : 1;

  bmxe_pkg::tok_t                  tok_r;
  logic [bmxe_pkg::DATA_W-1:0]     row_r;
  logic [bmxe_pkg::DATA_W-1:0]     rd_r;
  logic [bmxe_pkg::DATA_W-1:0]     acc_mem [PACKET_WORDS];
  logic [bmxe_pkg::DATA_W-1:0]     new_word;
  logic [AW-1:0]                   rd_addr;
  logic [AW-1:0]                   wr_addr;
  logic                            sel;
  logic                            done;

  assign rd_addr = AW'(tok_in.word_index);
  assign wr_addr = AW'(tok_r.word_index);
  assign done    = (ROW_ID == last_row);

  // Token stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else if (step) begin
      tok_r <= tok_in;
    end
  end

  // Matrix row load
  always_ff @(posedge clk) begin
    if (load.we && (load.row_sel == ROW_ID)) begin
      row_r <= load.bits;
    end
  end

  // Accumulator: read as the token arrives, write back as it leaves
  always_ff @(posedge clk) begin
    if (step && tok_in.vld) begin
      rd_r <= acc_mem[rd_addr];
    end
    if (step && tok_r.vld) begin
      acc_mem[wr_addr] <= new_word;
    end
  end

  // XOR fold; first column starts a fresh sum
  always_comb begin
    sel = row_r[tok_r.column];
    if (tok_r.col0) new_word = sel ? tok_r.data : '0;
    else            new_word = sel ? (rd_r ^ tok_r.data) : rd_r;
  end

  // Token stops on the final active row
  always_comb begin
    tok_out     = tok_r;
    tok_out.vld = tok_r.vld & ~done;
  end

  assign stat.tok_vld = tok_r.vld;
  assign stat.res_vld = tok_r.vld & tok_r.emit;
  assign stat.fin     = tok_r.vld & done;
  assign stat.word    = new_word;

endmodule

// File: rtl/bit_matrix_xor_erasure_encoder.sv
// ----------------------------------------------------------------------------
// bit_matrix_xor_erasure_encoder
// Cauchy Reed-Solomon style GF(2) bit-matrix encoder built as a chain of
// per-row cells; each data word walks the chain and folds into every row.
//
//   channel  dir  handshake            payload
//   in_      in   in_valid/in_stall    command, load_row, row_bits, column,
//                                      word_index, data_word
//   out_     out  out_valid/out_stall  code_row, word_index, code_word, last
//   cfg      in   APB psel/penable     data_parts (0x0), code_parts (0x4)
//
// A row load writes its cell's matrix row. A data word walks the active rows
// (clamped code_parts*WORD_BITS) one cell per cycle while the output is not
// stalled, each cell doing a read-modify-write of its accumulator memory.
// On the last column each row hands its word to the output register as the
// token passes it, so results leave one per cycle in row order unless stalled.
// A stalled output freezes the chain; no new request enters while a word walks.
// Reset (rst_n, synchronous) clears control only; matrix rows and
// accumulators hold no value until written.
// ----------------------------------------------------------------------------
module bit_matrix_xor_erasure_encoder #(
  parameter int WORD_BITS    = bmxe_pkg::WORD_BITS_DEF,
  parameter int PACKET_WORDS = bmxe_pkg::PACKET_WORDS_DEF,
  parameter int MAX_ROWS     = bmxe_pkg::MAX_ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input requests
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic [bmxe_pkg::ROW_W-1:0]    in_load_row,
  input  logic [bmxe_pkg::DATA_W-1:0]   in_row_bits,
  input  logic [bmxe_pkg::COL_W-1:0]    in_column,
  input  logic [bmxe_pkg::WIDX_W-1:0]   in_word_index,
  input  logic [bmxe_pkg::DATA_W-1:0]   in_data_word,
  // results
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bmxe_pkg::ROW_W-1:0]    out_code_row,
  output logic [bmxe_pkg::WIDX_W-1:0]   out_word_index,
  output logic [bmxe_pkg::DATA_W-1:0]   out_code_word,
  output logic                          out_last,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bmxe_pkg::ADDR_W-1:0]   paddr,
  input  logic [bmxe_pkg::PDATA_W-1:0]  pwdata,
  output logic [bmxe_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int PW_W = $clog2(PACKET_WORDS + 1) + 1;
  localparam logic [bmxe_pkg::CNT_W-1:0] MAX_ROWS_C = bmxe_pkg::CNT_W'(MAX_ROWS);
  localparam logic [bmxe_pkg::CNT_W-1:0] MAX_COLS_C = bmxe_pkg::CNT_W'(64);
  localparam logic [bmxe_pkg::CNT_W-1:0] WBITS_C    = bmxe_pkg::CNT_W'(WORD_BITS);
  localparam logic [PW_W-1:0]            PWORDS_C   = PW_W'(PACKET_WORDS);

  bmxe_pkg::cfg_t                 cfg;
  bmxe_pkg::load_t                load;
  bmxe_pkg::tok_t                 chain [MAX_ROWS+1];
  bmxe_pkg::cell_stat_t           stat  [MAX_ROWS];
  logic [MAX_ROWS-1:0]            tok_vld;

  logic [bmxe_pkg::CNT_W-1:0]     rows_raw, cols_raw, rows, cols;
  logic [bmxe_pkg::ROW_W-1:0]     last_row;
  logic [bmxe_pkg::COL_W-1:0]     last_col;
  logic                           in_acc, data_go, advance, step;
  logic                           busy_r, busy_nxt;
  logic [bmxe_pkg::WIDX_W-1:0]    cur_widx_r;

  logic                           res_any, fin_any, res_last;
  logic [bmxe_pkg::ROW_W-1:0]     res_row;
  logic [bmxe_pkg::DATA_W-1:0]    res_word;

  logic                           out_valid_r;
  logic [bmxe_pkg::ROW_W-1:0]     out_code_row_r;
  logic [bmxe_pkg::WIDX_W-1:0]    out_word_index_r;
  logic [bmxe_pkg::DATA_W-1:0]    out_code_word_r;
  logic                           out_last_r;

  // Configuration registers
  bmxe_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Active rows and columns
  always_comb begin
    rows_raw = bmxe_pkg::CNT_W'(bmxe_pkg::clamp_parts(cfg.code_parts)) * WBITS_C;
    cols_raw = bmxe_pkg::CNT_W'(bmxe_pkg::clamp_parts(cfg.data_parts)) * WBITS_C;
    rows     = (rows_raw > MAX_ROWS_C) ? MAX_ROWS_C : rows_raw;
    cols     = (cols_raw > MAX_COLS_C) ? MAX_COLS_C : cols_raw;
    last_row = bmxe_pkg::ROW_W'(rows - 1'b1);
    last_col = bmxe_pkg::COL_W'(cols - 1'b1);
  end

  // Handshake and chain control
  assign in_stall = busy_r;
  assign in_acc   = in_valid & ~in_stall;
  assign data_go  = in_acc && (in_command == bmxe_pkg::CMD_DATA)
                    && ({1'b0, in_column} < cols)
                    && (PW_W'(in_word_index) < PWORDS_C);
  assign advance  = ~(out_valid_r & out_stall);
  assign step     = advance | ~busy_r;

  // Row loads go straight to the owning cell
  assign load.we      = in_acc && (in_command == bmxe_pkg::CMD_ROW_LOAD);
  assign load.row_sel = in_load_row;
  assign load.bits    = in_row_bits;

  // Token entering the first cell
  always_comb begin
    chain[0].vld        = data_go;
    chain[0].col0       = (in_column == '0);
    chain[0].emit       = (in_column == last_col);
    chain[0].column     = in_column;
    chain[0].word_index = in_word_index;
    chain[0].data       = in_data_word;
  end

  // Row cells
  for (genvar k = 0; k < MAX_ROWS; k++) begin : g_cell
    bmxe_cell #(
      .PACKET_WORDS (PACKET_WORDS),
      .ROW_ID       (bmxe_pkg::ROW_W'(k))
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .step     (step),
      .last_row (last_row),
      .load     (load),
      .tok_in   (chain[k]),
      .tok_out  (chain[k+1]),
      .stat     (stat[k])
    );
    assign tok_vld[k] = stat[k].tok_vld;
  end

  // Pick the one reporting cell
  always_comb begin
    res_any  = 1'b0;
    fin_any  = 1'b0;
    res_last = 1'b0;
    res_row  = '0;
    res_word = '0;
    for (int k = 0; k < MAX_ROWS; k++) begin
      res_any  = res_any | stat[k].res_vld;
      fin_any  = fin_any | stat[k].fin;
      res_last = res_last | (stat[k].res_vld & stat[k].fin);
      res_row  = res_row | (bmxe_pkg::ROW_W'(k) & {bmxe_pkg::ROW_W{stat[k].res_vld}});
      res_word = res_word | (stat[k].word & {bmxe_pkg::DATA_W{stat[k].res_vld}});
    end
  end

  // Busy while a word walks the chain
  always_comb begin
    busy_nxt = busy_r;
    if (data_go)             busy_nxt = 1'b1;
    else if (fin_any && step) busy_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b0;
    else        busy_r <= busy_nxt;
  end

  // Word position of the word in flight
  always_ff @(posedge clk) begin
    if (data_go) cur_widx_r <= in_word_index;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_any;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_any) begin
      out_code_row_r   <= res_row;
      out_word_index_r <= cur_widx_r;
      out_code_word_r  <= res_word;
      out_last_r       <= res_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_row   = out_code_row_r;
  assign out_word_index = out_word_index_r;
  assign out_code_word  = out_code_word_r;
  assign out_last       = out_last_r;

  // Checks
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld))
    else $error("more than one token in the cell chain");

  a_busy_token: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (|tok_vld))
    else $error("busy flag disagrees with chain contents");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && out_valid_r && out_stall) |=> $stable(tok_vld))
    else $error("chain moved under a stalled result");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !chain[MAX_ROWS].vld)
    else $error("token ran past the last cell");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !busy_r) |=> !out_valid_r)
    else $error("result appeared with no word in flight");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bit-matrix XOR erasure encoder. Loads matrix
// rows, streams data columns per word position under a range of part
// counts, and checks every code word against a local parity predictor.
// ----------------------------------------------------------------------------

// One input request as the sender drives it
typedef struct packed {
  logic                          command;
  logic [bmxe_pkg::ROW_W-1:0]    load_row;
  logic [bmxe_pkg::DATA_W-1:0]   row_bits;
  logic [bmxe_pkg::COL_W-1:0]    column;
  logic [bmxe_pkg::WIDX_W-1:0]   word_index;
  logic [bmxe_pkg::DATA_W-1:0]   data_word;
} enc_request_t;

// One finished code word
typedef struct packed {
  logic [bmxe_pkg::ROW_W-1:0]    code_row;
  logic [bmxe_pkg::WIDX_W-1:0]   word_index;
  logic [bmxe_pkg::DATA_W-1:0]   code_word;
  logic                          last;
} code_word_t;

// Parity predictor: own copy of the bit matrix, accumulators and part counts
class parity_tracker;
  logic [63:0] matrix [bmxe_pkg::MAX_ROWS_DEF];
  logic [63:0] acc [bmxe_pkg::MAX_ROWS_DEF][bmxe_pkg::PACKET_WORDS_DEF];
  logic [3:0]  data_parts;
  logic [3:0]  code_parts;
  code_word_t  pending_words[$];
  int          errors;
  int          words_checked;

  function new();
    data_parts    = bmxe_pkg::DATA_PARTS_RST;
    code_parts    = bmxe_pkg::CODE_PARTS_RST;
    errors        = 0;
    words_checked = 0;
  endfunction

  // Rows or columns in use for a part count; 0 counts as 1, above 8 as 8
  static function int span(input logic [3:0] parts);
    int p;
    p = (parts == 4'd0) ? 1 : ((parts > 4'd8) ? 8 : int'(parts));
    return p * bmxe_pkg::WORD_BITS_DEF;
  endfunction

  function void set_reg(input logic idx, input logic [3:0] v);
    if (idx == bmxe_pkg::REG_DATA_PARTS) data_parts = v;
    else code_parts = v;
  endfunction

  // Fold one accepted request into the state; queue the code words it finishes
  function void note_request(input enc_request_t rq);
    int         rows;
    int         cols;
    logic       sel;
    code_word_t cw;
    if (rq.command == bmxe_pkg::CMD_ROW_LOAD) begin
      matrix[rq.load_row] = rq.row_bits;
      return;
    end
    rows = span(code_parts);
    cols = span(data_parts);
    if (rq.column >= cols) return;
    for (int r = 0; r < rows; r++) begin
      sel = matrix[r][rq.column];
      if (rq.column == 0) acc[r][rq.word_index] = sel ? rq.data_word : 64'd0;
      else if (sel) acc[r][rq.word_index] ^= rq.data_word;
    end
    if (rq.column == cols - 1) begin
      for (int r = 0; r < rows; r++) begin
        cw.code_row   = r[bmxe_pkg::ROW_W-1:0];
        cw.word_index = rq.word_index;
        cw.code_word  = acc[r][rq.word_index];
        cw.last       = (r == rows - 1);
        pending_words.push_back(cw);
      end
    end
  endfunction

  function void check_result(input code_word_t got);
    code_word_t want;
    words_checked++;
    if (pending_words.size() == 0) begin
      $error("code word with nothing expected: row %0d word %0d", got.code_row,
             got.word_index);
      errors++;
      return;
    end
    want = pending_words.pop_front();
    if (got.code_row !== want.code_row) begin
      $error("code_row: expected %0d, actual %0d", want.code_row, got.code_row);
      errors++;
    end
    if (got.word_index !== want.word_index) begin
      $error("out_word_index: expected %0d, actual %0d", want.word_index, got.word_index);
      errors++;
    end
    if (got.code_word !== want.code_word) begin
      $error("code_word: expected %h, actual %h", want.code_word, got.code_word);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, actual %0d", want.last, got.last);
      errors++;
    end
  endfunction
endclass

module testbench;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_command = bmxe_pkg::CMD_ROW_LOAD;
  logic [bmxe_pkg::ROW_W-1:0]    in_load_row = '0;
  logic [bmxe_pkg::DATA_W-1:0]   in_row_bits = '0;
  logic [bmxe_pkg::COL_W-1:0]    in_column = '0;
  logic [bmxe_pkg::WIDX_W-1:0]   in_word_index = '0;
  logic [bmxe_pkg::DATA_W-1:0]   in_data_word = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [bmxe_pkg::ROW_W-1:0]    out_code_row;
  logic [bmxe_pkg::WIDX_W-1:0]   out_word_index;
  logic [bmxe_pkg::DATA_W-1:0]   out_code_word;
  logic                          out_last;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [bmxe_pkg::ADDR_W-1:0]   paddr = '0;
  logic [bmxe_pkg::PDATA_W-1:0]  pwdata = '0;
  logic [bmxe_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;

  parity_tracker board;

  // Stimulus state: current shape, rows loaded, accumulators started per word
  int          rows_now;
  int          cols_now;
  logic [63:0] rows_live_mask;
  logic [63:0] rows_loaded = '0;
  logic [63:0] acc_live [bmxe_pkg::PACKET_WORDS_DEF];
  bit          offering = 1'b0;
  bit          hold_req = 1'b0;
  int          burst_left = 0;
  int          phase_count = 0;
  int          loads_sent = 0;
  int          words_sent = 0;
  int          ignored_sent = 0;
  int          settings_run = 0;

  bit_matrix_xor_erasure_encoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_load_row    (in_load_row),
    .in_row_bits    (in_row_bits),
    .in_column      (in_column),
    .in_word_index  (in_word_index),
    .in_data_word   (in_data_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_row   (out_code_row),
    .out_word_index (out_word_index),
    .out_code_word  (out_code_word),
    .out_last       (out_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      board.check_result(code_word_t'{out_code_row, out_word_index, out_code_word,
                                      out_last});
  end

  // Receiver stall pattern, plus one long hold-off on request
  initial begin : receiver
    int win_left;
    int pct;
    int hold_left;
    bit hold_done;
    win_left  = 0;
    pct       = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (win_left == 0) begin
          win_left = $urandom_range(8, 80);
          case ($urandom_range(0, 3))
            0: pct = 0;
            1: pct = 20;
            2: pct = 50;
            default: pct = 85;
          endcase
        end
        win_left--;
        out_stall <= ($urandom_range(1, 100) <= pct);
      end
    end
  end

  // Timeout
  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return {64{1'b1}};
      2: return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Every active row has an accumulator started for this word position
  function automatic bit widx_ready(input int w);
    return (acc_live[w] & rows_live_mask) == rows_live_mask;
  endfunction

  // Offer one request, hold it until accepted, then maybe open a gap
  task automatic send_request(input enc_request_t rq);
    int gap;
    in_valid      <= 1'b1;
    in_command    <= rq.command;
    in_load_row   <= rq.load_row;
    in_row_bits   <= rq.row_bits;
    in_column     <= rq.column;
    in_word_index <= rq.word_index;
    in_data_word  <= rq.data_word;
    offering = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.note_request(rq);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_load(input int row, input logic [63:0] bits);
    enc_request_t rq;
    rq.command    = bmxe_pkg::CMD_ROW_LOAD;
    rq.load_row   = row[bmxe_pkg::ROW_W-1:0];
    rq.row_bits   = bits;
    rq.column     = $urandom;
    rq.word_index = $urandom;
    rq.data_word  = {$urandom, $urandom};
    rows_loaded[row] = 1'b1;
    loads_sent++;
    phase_count++;
    send_request(rq);
  endtask

  task automatic send_data(input int col, input int w, input logic [63:0] word);
    enc_request_t rq;
    rq.command    = bmxe_pkg::CMD_DATA;
    rq.load_row   = $urandom;
    rq.row_bits   = {$urandom, $urandom};
    rq.column     = col[bmxe_pkg::COL_W-1:0];
    rq.word_index = w[bmxe_pkg::WIDX_W-1:0];
    rq.data_word  = word;
    if (col < cols_now) begin
      words_sent++;
      phase_count++;
      if (col == 0) acc_live[w] |= rows_live_mask;
    end else begin
      ignored_sent++;
    end
    send_request(rq);
  endtask

  // Stray request between columns: reload, out-of-range column or random column
  task automatic send_noise();
    int w;
    int c;
    w = $urandom_range(0, bmxe_pkg::PACKET_WORDS_DEF - 1);
    case ($urandom_range(0, 2))
      0: send_load($urandom_range(0, 63), rand_word());
      1: begin
        if (cols_now < 64) send_data($urandom_range(cols_now, 63), w, rand_word());
        else send_load($urandom_range(0, 63), rand_word());
      end
      default: begin
        c = $urandom_range(0, cols_now - 1);
        if (c != 0 && !widx_ready(w)) c = 0;
        send_data(c, w, rand_word());
      end
    endcase
  endtask

  task automatic cfg_access(input logic is_write, input logic idx,
                            input logic [bmxe_pkg::PDATA_W-1:0] wdata,
                            output logic [bmxe_pkg::PDATA_W-1:0] rdata);
    logic [bmxe_pkg::ADDR_W-1:0] a;
    a = '0;
    a[bmxe_pkg::REG_IDX_BIT] = idx;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= a;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic idx, input logic [3:0] want);
    logic [bmxe_pkg::PDATA_W-1:0] rd;
    cfg_access(1'b0, idx, '0, rd);
    if (rd[3:0] !== want) begin
      $error("register %0d readback: expected %0d, actual %0d", idx, want, rd[3:0]);
      board.errors++;
    end
  endtask

  // Write both part counts (upper data bits are don't-care) and read them back
  task automatic apply_setting(input logic [3:0] dp, input logic [3:0] cp);
    logic [bmxe_pkg::PDATA_W-1:0] rd;
    cfg_access(1'b1, bmxe_pkg::REG_DATA_PARTS, {28'($urandom), dp}, rd);
    board.set_reg(bmxe_pkg::REG_DATA_PARTS, dp);
    check_reg(bmxe_pkg::REG_DATA_PARTS, dp);
    cfg_access(1'b1, bmxe_pkg::REG_CODE_PARTS, {28'($urandom), cp}, rd);
    board.set_reg(bmxe_pkg::REG_CODE_PARTS, cp);
    check_reg(bmxe_pkg::REG_CODE_PARTS, cp);
    rows_now = board.span(cp);
    cols_now = board.span(dp);
    rows_live_mask = (rows_now == 64) ? {64{1'b1}} : ((64'd1 << rows_now) - 64'd1);
    phase_count = 0;
    settings_run++;
  endtask

  // Drain all results and let any walking word finish before touching registers
  task automatic settle();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    while (board.pending_words.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic load_missing();
    for (int r = 0; r < rows_now; r++)
      if (!rows_loaded[r]) send_load(r, rand_word());
  endtask

  // Column sequences per word position, some cut short or resumed, with noise
  task automatic run_stream(input int budget, input bit arm_hold);
    int w;
    int first;
    int stop_at;
    while (phase_count < budget) begin
      w = $urandom_range(0, bmxe_pkg::PACKET_WORDS_DEF - 1);
      first = 0;
      if (widx_ready(w) && $urandom_range(0, 7) == 0)
        first = $urandom_range(1, cols_now - 1);
      stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(first, cols_now - 1)
                                            : cols_now - 1;
      for (int c = first; c <= stop_at; c++) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        if (arm_hold && phase_count >= 20) hold_req = 1'b1;
        send_data(c, w, rand_word());
      end
    end
  endtask

  initial begin
    board = new();
    for (int i = 0; i < bmxe_pkg::PACKET_WORDS_DEF; i++) acc_live[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset values, one part each way, row and word extremes
    check_reg(bmxe_pkg::REG_DATA_PARTS, bmxe_pkg::DATA_PARTS_RST);
    check_reg(bmxe_pkg::REG_CODE_PARTS, bmxe_pkg::CODE_PARTS_RST);
    apply_setting(4'd1, 4'd1);
    send_load(0, 64'd0);
    send_load(1, {64{1'b1}});
    send_load(2, 64'h1);
    send_load(3, 64'h80);
    send_load(4, 64'hFFFF_FFFF_FFFF_FF00);
    send_load(5, 64'h55);
    send_load(6, 64'hAA);
    send_load(7, rand_word());
    for (int c = 0; c < 8; c++) begin
      if (c == 4) send_data(63, 0, {64{1'b1}});
      send_data(c, 0, (c == 0) ? {64{1'b1}} : ((c == 1) ? 64'd0 : rand_word()));
    end
    for (int c = 0; c < 8; c++)
      send_data(c, 15, (c == 7) ? {64{1'b1}} : rand_word());

    // Random phases over several settings, extremes and clamped values included
    settle(); apply_setting(4'd2, 4'd1);  load_missing(); run_stream(50, 1'b1);
    settle(); apply_setting(4'd8, 4'd8);  load_missing(); run_stream(70, 1'b0);
    settle(); apply_setting(4'd0, 4'd15); load_missing(); run_stream(50, 1'b0);
    settle(); apply_setting(4'd15, 4'd0); load_missing(); run_stream(40, 1'b0);
    settle(); apply_setting(4'd3, 4'd5);  load_missing(); run_stream(50, 1'b0);
    settle(); apply_setting(4'd4, 4'd2);  load_missing(); run_stream(50, 1'b0);
    settle();
    apply_setting(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    load_missing();
    run_stream(50, 1'b0);
    settle();

    $display("Covered %0d row loads, %0d data words and %0d out-of-range words",
             loads_sent, words_sent, ignored_sent);
    $display("over %0d part-count settings; %0d code words checked.",
             settings_run, board.words_checked);
    if (board.errors == 0 && board.pending_words.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
